@@ src/lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd_pkg: shared constants, types and keyword table
// Store sizing, result codes and the fixed keyword set of the line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int LEN_W         = $clog2(LINE_CAPACITY);

	localparam int KW_COUNT = 13;
	localparam int KW_MAX   = 13;
	localparam int POS_W    = $clog2(KW_MAX + 1);

	localparam logic [3:0] CODE_EMPTY    = 4'd13;
	localparam logic [3:0] CODE_OVERFLOW = 4'd14;
	localparam logic [3:0] CODE_UNKNOWN  = 4'd15;

	localparam logic [7:0] BYTE_CR = 8'd13;
	localparam logic [7:0] BYTE_LF = 8'd10;

	typedef struct packed {
		logic             start;
		logic             step;
		logic [POS_W-1:0] pos;
		logic [7:0]       ch;
	} match_req_t;

	typedef struct packed {
		logic [3:0] code_zero;
		logic [3:0] code_upd;
	} match_res_t;

	// keyword text, right-aligned: last character in the low byte
	function automatic logic [8*KW_MAX-1:0] kw_text(input int k);
		logic [8*KW_MAX-1:0] t;
		case (k)
			0:  t = "on";
			1:  t = "off";
			2:  t = "on-unack";
			3:  t = "off-unack";
			4:  t = "tx-low";
			5:  t = "tx-normal";
			6:  t = "status";
			7:  t = "help";
			8:  t = "lidar-status";
			9:  t = "lidar-info";
			10: t = "lidar-health";
			11: t = "lidar-rx-test";
			12: t = "factory-reset";
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic int kw_len(input int k);
		int l;
		case (k)
			0:  l = 2;
			1:  l = 3;
			2:  l = 8;
			3:  l = 9;
			4:  l = 6;
			5:  l = 9;
			6:  l = 6;
			7:  l = 4;
			8:  l = 12;
			9:  l = 10;
			10: l = 12;
			11: l = 13;
			12: l = 13;
			default: l = 0;
		endcase
		return l;
	endfunction

	// character at a position of a keyword, zero past its end
	function automatic logic [7:0] kw_char(input int k, input logic [POS_W-1:0] p);
		logic [8*KW_MAX-1:0] t;
		int                  l;
		int                  pi;
		t  = kw_text(k);
		l  = kw_len(k);
		pi = int'(p);
		if (pi >= l)
			return 8'd0;
		return t[8*(l-1-pi) +: 8];
	endfunction

endpackage

`default_nettype wire

@@ src/lcd_line_ram.sv @@
// ----------------------------------------------------------------------------
// lcd_line_ram: line character store
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_line_ram #(
	parameter int DEPTH  = 63,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/lcd_kw_match.sv @@
// ----------------------------------------------------------------------------
// lcd_kw_match: keyword candidate tracker
// Keeps one live bit per keyword while the stored line is scanned a character
// at a time, and encodes the resulting command code.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_kw_match (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcd_pkg::match_req_t req,
	output lcd_pkg::match_res_t      res
);

	import lcd_pkg::*;

	logic [KW_COUNT-1:0] mask_q;
	logic [KW_COUNT-1:0] mask_upd;

	// code for a text of the given length with the given live candidates
	function automatic logic [3:0] pick(input logic [KW_COUNT-1:0] m,
			input logic [POS_W:0] used);
		logic [3:0] c;
		c = CODE_UNKNOWN;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (m[k] && int'(used) == kw_len(k))
				c = 4'(k);
		end
		if (used == '0)
			c = CODE_EMPTY;
		return c;
	endfunction

	always_comb begin
		for (int k = 0; k < KW_COUNT; k++)
			mask_upd[k] = mask_q[k] && (kw_char(k, req.pos) == req.ch);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (req.start) begin
			mask_q <= '1;
		end else if (req.step) begin
			mask_q <= mask_upd;
		end
	end

	// zero byte at pos: text ends before it; otherwise it includes this char
	assign res.code_zero = pick(mask_q, {1'b0, req.pos});
	assign res.code_upd  = pick(mask_upd, {1'b0, req.pos} + 1'b1);

endmodule

`default_nettype wire

@@ src/line_command_decoder.sv @@
// ----------------------------------------------------------------------------
// line_command_decoder: text line to command code
// Collects received characters into a line store and decodes each finished
// line against a fixed keyword set.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/rx_byte carry one received byte per transaction.
//   out_valid/out_ready/command_code carry one code per finished line.
//   Ordinary bytes and a line feed swallowed after a carriage return give
//   no result. A CR or LF ends the line: the stored text is read back from
//   the line RAM one character a cycle (pipelined behind the registered RAM
//   read) for at most 14 characters, and its code is then loaded into the
//   output register. An overflowed or empty line skips the scan.
//   Input is refused during the scan and while a finished code waits for a
//   free output register; a code already in the output register does not
//   hold off ordinary bytes. When the receiver stalls, command_code holds.
//   Reset clears the length, overflow and CR flags and the output valid; the
//   line RAM is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module line_command_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [3:0] command_code
);

	import lcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             skip_q;
	logic [POS_W-1:0] limit_q;
	logic [POS_W-1:0] addr_q;
	logic [3:0]       result_q;
	logic             out_valid_q;
	logic [3:0]       code_q;

	logic             rd_valid_s1;
	logic [POS_W-1:0] rd_pos_s1;

	logic             accept;
	logic             is_cr;
	logic             is_lf;
	logic             wr_en;
	logic             rd_en;
	logic [7:0]       rd_data;
	logic             step;
	match_req_t       mreq;
	match_res_t       mres;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_cr    = (rx_byte == BYTE_CR);
	assign is_lf    = (rx_byte == BYTE_LF);

	assign wr_en = accept && !(skip_q && is_lf) && !is_cr && !is_lf && !ovf_q &&
			(len_q < LEN_W'(STORE_DEPTH));
	assign rd_en = (state_q == ST_SCAN) && (addr_q < limit_q);
	assign step  = (state_q == ST_SCAN) && rd_valid_s1 && (rd_data != 8'd0);

	assign mreq.start = accept && (is_cr || is_lf);
	assign mreq.step  = step;
	assign mreq.pos   = rd_pos_s1;
	assign mreq.ch    = rd_data;

	lcd_line_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (8),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (rd_en),
		.raddr(ADDR_W'(addr_q)),
		.rdata(rd_data)
	);

	lcd_kw_match u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.res   (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_pos_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			skip_q      <= 1'b0;
			limit_q     <= '0;
			addr_q      <= '0;
			result_q    <= '0;
			out_valid_q <= 1'b0;
			code_q      <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						skip_q <= 1'b0;
						if (skip_q && is_lf) begin
							// line feed of a CR LF pair, nothing to do
						end else if (!is_cr && !is_lf) begin
							if (!ovf_q) begin
								if (len_q < LEN_W'(STORE_DEPTH))
									len_q <= len_q + 1'b1;
								else
									ovf_q <= 1'b1;
							end
						end else begin
							skip_q <= is_cr;
							ovf_q  <= 1'b0;
							len_q  <= '0;
							addr_q <= '0;
							// texts longer than any keyword need only one extra char
							if (len_q < LEN_W'(KW_MAX + 1))
								limit_q <= POS_W'(len_q);
							else
								limit_q <= POS_W'(KW_MAX + 1);
							if (ovf_q) begin
								result_q <= CODE_OVERFLOW;
								state_q  <= ST_DONE;
							end else if (len_q == '0) begin
								result_q <= CODE_EMPTY;
								state_q  <= ST_DONE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end

				ST_SCAN: begin
					if (rd_en)
						addr_q <= addr_q + 1'b1;
					if (rd_valid_s1) begin
						if (rd_data == 8'd0) begin
							result_q <= mres.code_zero;
							state_q  <= ST_DONE;
						end else if (rd_pos_s1 == limit_q - 1'b1) begin
							result_q <= mres.code_upd;
							state_q  <= ST_DONE;
						end
					end
				end

				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						code_q      <= result_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = code_q;

endmodule

`default_nettype wire
